[design/bmhq_pkg.sv]
// Shared types, codes and constants of the binary min-heap queue.
package bmhq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 32;
    localparam int STAT_W       = 2;
    localparam int COUNT_OUT_W  = 7;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    // controller to datapath
    typedef struct packed {
        logic    start;       // capture key, seed position, clear result key
        logic    rd_deq;      // read root and last entry
        logic    rd_down;     // read both children of the current position
        logic    take_root;   // hold root as result, last entry as moving key
        logic    wr_key;      // store moving key at current position
        logic    wr_move_up;  // move parent down, climb one level
        logic    wr_move_dn;  // move smaller child up, descend one level
        logic    cnt_inc;
        logic    res_load;    // load output registers
        status_t res_status;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic last_one;
        logic pos_zero;
        logic leaf;
        logic up_less;
        logic dn_less;
    } stat_t;

endpackage

[design/bmhq_dp.sv]
// Heap datapath: key memory, entry count, position walk and output registers.
module bmhq_dp
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    input  logic [KEY_W-1:0]       key_in,
    output stat_t                  stat,
    output logic [KEY_W-1:0]       key_out,
    output logic [STAT_W-1:0]      status,
    output logic [COUNT_OUT_W-1:0] count_out
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = IW + 2;

    logic [KEY_W-1:0] mem [CAPACITY];
    logic [KEY_W-1:0] rd_a_reg;
    logic [KEY_W-1:0] rd_b_reg;

    logic [CW-1:0]    count_reg;
    logic [IW-1:0]    pos_reg;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] res_key_reg;
    logic [KEY_W-1:0] key_out_reg;
    logic [STAT_W-1:0] status_reg;
    logic [COUNT_OUT_W-1:0] count_out_reg;

    logic [IW-1:0]    parent;
    logic [LW-1:0]    left;
    logic [LW-1:0]    right;
    logic             right_ok;
    logic             pick_right;
    logic [IW-1:0]    pick_idx;
    logic [KEY_W-1:0] pick_val;
    logic [IW-1:0]    rd_addr_a;
    logic [IW-1:0]    rd_addr_b;
    logic             wr_en;
    logic [KEY_W-1:0] wr_data;
    logic [31:0]      count_wide;

    assign parent   = (pos_reg - IW'(1)) >> 1;
    assign left     = {1'b0, pos_reg, 1'b1};
    assign right    = left + LW'(1);
    assign right_ok = right < LW'(count_reg);

    assign pick_right = right_ok && ($signed(rd_b_reg) < $signed(rd_a_reg));
    assign pick_idx   = pick_right ? right[IW-1:0] : left[IW-1:0];
    assign pick_val   = pick_right ? rd_b_reg : rd_a_reg;

    always_comb
    begin
        rd_addr_a = parent;
        rd_addr_b = right[IW-1:0];
        if (cmd.rd_deq)
        begin
            rd_addr_a = '0;
            rd_addr_b = IW'(count_reg - CW'(1));
        end
        else if (cmd.rd_down)
        begin
            rd_addr_a = left[IW-1:0];
        end
    end

    assign wr_en   = cmd.wr_key | cmd.wr_move_up | cmd.wr_move_dn;
    assign wr_data = cmd.wr_move_up ? rd_a_reg :
                     cmd.wr_move_dn ? pick_val : key_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pos_reg] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            count_reg <= count_reg + CW'(1);
        end
        else if (cmd.take_root)
        begin
            count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg     <= key_in;
            pos_reg     <= count_reg[IW-1:0];
            res_key_reg <= '0;
        end
        else if (cmd.take_root)
        begin
            key_reg     <= rd_b_reg;
            pos_reg     <= '0;
            res_key_reg <= rd_a_reg;
        end
        else if (cmd.wr_move_up)
        begin
            pos_reg <= parent;
        end
        else if (cmd.wr_move_dn)
        begin
            pos_reg <= pick_idx;
        end
    end

    assign count_wide = 32'(count_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            key_out_reg   <= res_key_reg;
            status_reg    <= cmd.res_status;
            count_out_reg <= count_wide[COUNT_OUT_W-1:0];
        end
    end

    assign stat.full     = count_reg == CW'(CAPACITY);
    assign stat.empty    = count_reg == '0;
    assign stat.last_one = count_reg == CW'(1);
    assign stat.pos_zero = pos_reg == '0;
    assign stat.leaf     = left >= LW'(count_reg);
    assign stat.up_less  = $signed(key_reg) < $signed(rd_a_reg);
    assign stat.dn_less  = $signed(pick_val) < $signed(key_reg);

    assign key_out   = key_out_reg;
    assign status    = status_reg;
    assign count_out = count_out_reg;

endmodule

[design/bmhq_ctrl.sv]
// Heap controller: sequences sift-up, sift-down and the output handshake.
module bmhq_ctrl
    import bmhq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  logic  operation,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_UP_RD  = 8'b0000_0010,
        ST_UP_CMP = 8'b0000_0100,
        ST_DQ_RD  = 8'b0000_1000,
        ST_DQ_LD  = 8'b0001_0000,
        ST_DN_RD  = 8'b0010_0000,
        ST_DN_CMP = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    status_t res_reg;
    status_t res_next;
    logic    out_valid_reg;
    logic    out_valid_next;

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.res_status = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    res_next  = STAT_OK;
                    if (op_t'(operation) == OP_DEQ)
                    begin
                        if (stat.empty)
                        begin
                            res_next   = STAT_EMPTY;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            state_next = ST_DQ_RD;
                        end
                    end
                    else if (stat.full)
                    begin
                        res_next   = STAT_FULL;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_UP_RD;
                    end
                end
            end
            ST_UP_RD:
            begin
                // at the root: store without a compare
                if (stat.pos_zero)
                begin
                    cmd.wr_key  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                if (stat.up_less)
                begin
                    cmd.wr_move_up = 1'b1;
                    state_next     = ST_UP_RD;
                end
                else
                begin
                    cmd.wr_key  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = ST_FINISH;
                end
            end
            ST_DQ_RD:
            begin
                cmd.rd_deq = 1'b1;
                state_next = ST_DQ_LD;
            end
            ST_DQ_LD:
            begin
                cmd.take_root = 1'b1;
                state_next    = stat.last_one ? ST_FINISH : ST_DN_RD;
            end
            ST_DN_RD:
            begin
                if (stat.leaf)
                begin
                    cmd.wr_key = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.rd_down = 1'b1;
                    state_next  = ST_DN_CMP;
                end
            end
            ST_DN_CMP:
            begin
                if (stat.dn_less)
                begin
                    cmd.wr_move_dn = 1'b1;
                    state_next     = ST_DN_RD;
                end
                else
                begin
                    cmd.wr_key = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_reg       <= STAT_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[design/binary_min_heap_queue.sv]
// Each heap level takes a registered memory read, then a compare and write.
// A new access is taken only while idle: once the result of the last one is in the
// output register, even while that result still waits for out_ready.
// A full enqueue or an empty dequeue skips the heap walk and goes straight to the result.
// Reset clears the entry count, the controller and the output valid; keys are not cleared.
module binary_min_heap_queue
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   operation,
    input  logic [KEY_W-1:0]       key_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [KEY_W-1:0]       key_out,
    output logic [STAT_W-1:0]      status,
    output logic [COUNT_OUT_W-1:0] count_out
);

    cmd_t  cmd;
    stat_t stat;

    bmhq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bmhq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .key_in    (key_in),
        .stat      (stat),
        .key_out   (key_out),
        .status    (status),
        .count_out (count_out)
    );

endmodule

[tb/tb_binary_min_heap_queue.sv]
`timescale 1ns / 100ps
// Testbench for the binary min-heap queue: directed and random accesses checked against a heap predictor.
module tb_binary_min_heap_queue;
    import bmhq_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 24;

    typedef struct packed {
        logic [KEY_W-1:0]       key;
        status_t                stat;
        logic [COUNT_OUT_W-1:0] count;
    } heap_result_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic                   operation = 1'b0;
    logic [KEY_W-1:0]       key_in    = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [KEY_W-1:0]       key_out;
    logic [STAT_W-1:0]      status;
    logic [COUNT_OUT_W-1:0] count_out;

    logic signed [KEY_W-1:0] heap_keys [CAPACITY_DEF];
    int                      heap_size = 0;
    heap_result_t            pending_results [$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int err_count    = 0;

    binary_min_heap_queue #(
        .CAPACITY (CAPACITY_DEF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .key_in    (key_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .key_out   (key_out),
        .status    (status),
        .count_out (count_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Apply one access to the predicted heap and return the result it yields.
    function automatic heap_result_t heap_access(op_t op, logic signed [KEY_W-1:0] key);
        heap_result_t            res;
        int                      pos;
        int                      up;
        int                      child;
        bit                      moving;
        logic signed [KEY_W-1:0] carry;
        res = '{key: '0, stat: STAT_OK, count: '0};
        if (op == OP_ENQ) begin
            if (heap_size >= CAPACITY_DEF) begin
                res.stat = STAT_FULL;
            end else begin
                pos = heap_size;
                moving = 1'b1;
                while (moving && pos > 0) begin
                    up = (pos - 1) / 2;
                    if (key < heap_keys[up]) begin
                        heap_keys[pos] = heap_keys[up];
                        pos = up;
                    end else begin
                        moving = 1'b0;
                    end
                end
                heap_keys[pos] = key;
                heap_size++;
            end
        end else begin
            if (heap_size == 0) begin
                res.stat = STAT_EMPTY;
            end else begin
                res.key = heap_keys[0];
                heap_size--;
                if (heap_size > 0) begin
                    carry = heap_keys[heap_size];
                    pos = 0;
                    moving = 1'b1;
                    while (moving) begin
                        child = 2 * pos + 1;
                        if (child >= heap_size) begin
                            moving = 1'b0;
                        end else begin
                            // left child wins ties
                            if (child + 1 < heap_size && heap_keys[child + 1] < heap_keys[child])
                                child++;
                            if (heap_keys[child] < carry) begin
                                heap_keys[pos] = heap_keys[child];
                                pos = child;
                            end else begin
                                moving = 1'b0;
                            end
                        end
                    end
                    heap_keys[pos] = carry;
                end
            end
        end
        res.count = heap_size[COUNT_OUT_W-1:0];
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        int pick;
        pick = $urandom_range(9);
        case (pick)
            0: begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            // narrow range to force equal keys
            1, 2, 3: return $signed($urandom_range(8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    function automatic void flag_mismatch(string field, logic [KEY_W-1:0] want,
                                          logic [KEY_W-1:0] got);
        err_count++;
        if (err_count <= 10)
            $display("mismatch on %s: expected %0d, got %0d", field, $signed(want), $signed(got));
    endfunction

    // Send one access, wait for its transfer, then record its predicted result.
    task automatic send_access(op_t op, logic [KEY_W-1:0] key);
        bit taken;
        if ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        in_valid  <= 1'b1;
        operation <= op;
        key_in    <= key;
        do begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end while (!taken);
        pending_results.push_back(heap_access(op, key));
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Empty dequeue, extreme keys, equal keys, single-entry dequeue, ignored dequeue key.
    task automatic test_boundary_keys();
        send_access(OP_DEQ, 32'h5A5A_A5A5);
        send_access(OP_ENQ, 32'h7FFF_FFFF);
        send_access(OP_ENQ, 32'h8000_0000);
        send_access(OP_ENQ, 32'h0000_0000);
        send_access(OP_ENQ, 32'hFFFF_FFFF);
        send_access(OP_ENQ, 32'h0000_0001);
        send_access(OP_ENQ, 32'h0000_0005);
        send_access(OP_ENQ, 32'h0000_0005);
        send_access(OP_ENQ, 32'h0000_0005);
        repeat (8) send_access(OP_DEQ, 32'hFFFF_FFFF);
        send_access(OP_DEQ, 32'h0000_0000);
        send_access(OP_ENQ, 32'hDEAD_BEEF);
        send_access(OP_DEQ, 32'h0000_0000);
        send_access(OP_DEQ, 32'h8000_0000);
    endtask

    // Fill to capacity, push past it, then drain to empty and one beyond.
    task automatic test_fill_past_capacity();
        repeat (CAPACITY_DEF - heap_size + 3) send_access(OP_ENQ, random_key());
        repeat (CAPACITY_DEF + 1) send_access(OP_DEQ, random_key());
    endtask

    task automatic test_random_traffic(int accesses, int enq_pct);
        repeat (accesses) begin
            if ($urandom_range(99) < enq_pct)
                send_access(OP_ENQ, random_key());
            else
                send_access(OP_DEQ, random_key());
        end
    endtask

    // Check each result transfer; sampled away from the active edge.
    initial
    begin
        heap_result_t want;
        forever begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("result with no access pending: key_out %0d status %0d count %0d",
                                 $signed(key_out), status, count_out);
                end else begin
                    want = pending_results.pop_front();
                    if (key_out !== want.key)
                        flag_mismatch("key_out", want.key, key_out);
                    if (status !== want.stat)
                        flag_mismatch("status", want.stat, status);
                    if (count_out !== want.count)
                        flag_mismatch("count_out", want.count, count_out);
                end
            end
        end
    end

    initial
    begin
        forever begin
            @(posedge clk);
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_binary_min_heap_queue: errors");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        test_boundary_keys();

        tx_idle_pct  = 75;
        rx_stall_pct = 0;
        test_fill_past_capacity();

        tx_idle_pct  = 0;
        rx_stall_pct = 75;
        test_random_traffic(110, 70);
        pause_until_drained();

        tx_idle_pct  = 37;
        rx_stall_pct = 37;
        test_random_traffic(110, 30);

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        test_random_traffic(110, 55);

        tx_idle_pct  = 75;
        rx_stall_pct = 75;
        test_fill_past_capacity();

        tx_idle_pct  = 37;
        rx_stall_pct = 37;
        test_random_traffic(30, 60);

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0) begin
            err_count++;
            $display("%0d results never arrived", pending_results.size());
        end

        if (err_count == 0)
            $display("tb_binary_min_heap_queue: clean");
        else
            $display("tb_binary_min_heap_queue: errors");
        $finish;
    end

endmodule
